// File: design/ccbsp_pkg.sv
// Package for the color code block stream parser.
// Holds field widths, stream constants and configuration register indexes.
// No dependencies.
package ccbsp_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int WINDOW_W  = 3 * BYTE_W;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_W     = 3;
    localparam int SEEN_W    = 2;
    localparam int NUM_SLOTS = 2;

    localparam logic [BYTE_W-1:0] SYNC_LO   = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_HI   = 8'haa;
    localparam logic [BYTE_W-1:0] CC_LO     = 8'h56;
    localparam logic [WORD_W-1:0] NOT_FOUND = 16'hffff;

    localparam logic [CNT_W-1:0] CNT_START   = 3'd6;
    localparam logic [CNT_W-1:0] CNT_SIG_LO  = 3'd4;
    localparam logic [CNT_W-1:0] CNT_SIG_HI  = 3'd3;
    localparam logic [CNT_W-1:0] CNT_LOC_LO  = 3'd2;
    localparam logic [CNT_W-1:0] CNT_LOC_HI  = 3'd1;
    localparam logic [SEEN_W-1:0] SEEN_FULL  = 2'd3;

    localparam logic [WORD_W-1:0] NEAR_OFFSET = 16'd2;
    localparam logic [WORD_W-1:0] NEAR_SPAN   = 16'd4;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_COLOR_SIG  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_COLOR_SIG = 1'd1;

    localparam logic [WORD_W-1:0] FIRST_COLOR_RESET  = 16'd1;
    localparam logic [WORD_W-1:0] SECOND_COLOR_RESET = 16'd2;

    typedef struct packed {
        logic              first_found;
        logic [WORD_W-1:0] first_sig;
        logic [WORD_W-1:0] first_loc;
        logic              second_found;
        logic [WORD_W-1:0] second_sig;
        logic [WORD_W-1:0] second_loc;
        logic              pair_accept;
    } result_t;

endpackage

// File: design/ccbsp_in_if.sv
// Input stream channel of the color code block stream parser.
// Carries valid, ready and one received byte with its end-of-buffer mark.
// Depends on ccbsp_pkg.
interface ccbsp_in_if import ccbsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: design/ccbsp_out_if.sv
// Result channel of the color code block stream parser.
// Carries valid, ready and the per-buffer result fields.
// Depends on ccbsp_pkg.
interface ccbsp_out_if import ccbsp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              first_found;
    logic [WORD_W-1:0] first_sig;
    logic [WORD_W-1:0] first_loc;
    logic              second_found;
    logic [WORD_W-1:0] second_sig;
    logic [WORD_W-1:0] second_loc;
    logic              pair_accept;

    modport source (
        output valid, output first_found, output first_sig, output first_loc,
        output second_found, output second_sig, output second_loc,
        output pair_accept, input ready
    );
    modport sink (
        input valid, input first_found, input first_sig, input first_loc,
        input second_found, input second_sig, input second_loc,
        input pair_accept, output ready
    );
endinterface

// File: design/color_code_block_stream_parser.sv
// Color code block stream parser: header search, two capture slots and result build.
// Result: the result of a buffer is valid in the cycle after its last byte transfer.
// Throughput: one byte per cycle; a byte is taken whenever the result register is
// empty or being drained in the same cycle.
// Reset: asynchronous, active low; clears the buffer state and loads the color
// registers with 1 and 2. Depends on ccbsp_pkg, ccbsp_in_if and ccbsp_out_if.
module color_code_block_stream_parser import ccbsp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ccbsp_in_if.sink             stream,
    ccbsp_out_if.source          result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    logic [WORD_W-1:0]   color0_reg;
    logic [WORD_W-1:0]   color1_reg;

    logic [WINDOW_W-1:0] window_reg;
    logic [WINDOW_W-1:0] window_next;
    logic [SEEN_W-1:0]   seen_reg;
    logic [SEEN_W-1:0]   seen_next;
    logic                done_reg;
    logic                done_next;
    logic [NUM_SLOTS-1:0] open_reg;
    logic [NUM_SLOTS-1:0] open_next;
    logic [CNT_W-1:0]    cnt_reg  [NUM_SLOTS];
    logic [CNT_W-1:0]    cnt_next [NUM_SLOTS];
    logic [WORD_W-1:0]   sig_reg  [NUM_SLOTS];
    logic [WORD_W-1:0]   sig_next [NUM_SLOTS];
    logic [WORD_W-1:0]   loc_reg  [NUM_SLOTS];
    logic [WORD_W-1:0]   loc_next [NUM_SLOTS];

    logic                out_valid_reg;
    result_t             out_reg;
    result_t             res_next;

    logic                take;
    logic                tail;
    logic                lead;
    logic                found0;
    logic                found1;
    logic [WORD_W-1:0]   s1;
    logic [WORD_W-1:0]   l1;
    logic [WORD_W-1:0]   s2;
    logic [WORD_W-1:0]   l2;
    logic [WORD_W-1:0]   near_base;
    logic [WORD_W:0]     near_diff;
    logic                near;

    function automatic logic is_color(input logic [WORD_W-1:0] sig,
                                      input logic [WORD_W-1:0] c0,
                                      input logic [WORD_W-1:0] c1);
        return (sig == c0) || (sig == c1);
    endfunction

    assign stream.ready = !out_valid_reg || result.ready;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        open_next = open_reg;
        done_next = done_reg;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            cnt_next[s] = cnt_reg[s];
            sig_next[s] = sig_reg[s];
            loc_next[s] = loc_reg[s];
            if (open_reg[s] && (cnt_reg[s] != '0))
            begin
                case (cnt_reg[s])
                    CNT_SIG_LO: sig_next[s][BYTE_W-1:0]        = stream.data_byte;
                    CNT_SIG_HI: sig_next[s][WORD_W-1:BYTE_W]   = stream.data_byte;
                    CNT_LOC_LO: loc_next[s][BYTE_W-1:0]        = stream.data_byte;
                    CNT_LOC_HI: loc_next[s][WORD_W-1:BYTE_W]   = stream.data_byte;
                    default:    ;
                endcase
                cnt_next[s] = cnt_reg[s] - 1'b1;
            end
        end

        tail = (window_reg[BYTE_W-1:0] == CC_LO) && (stream.data_byte == SYNC_HI);
        lead = (window_reg[WINDOW_W-1:2*BYTE_W] == SYNC_LO)
            && (window_reg[2*BYTE_W-1:BYTE_W] == SYNC_HI);

        if (!done_reg && (seen_reg == SEEN_FULL))
        begin
            if (tail && lead && !open_reg[0])
            begin
                open_next[0] = 1'b1;
                cnt_next[0]  = CNT_START;
            end
            else if (tail && !lead && !open_reg[1])
            begin
                open_next[1] = 1'b1;
                cnt_next[1]  = CNT_START;
            end
            if (open_next[0] && open_next[1])
            begin
                done_next = 1'b1;
            end
        end

        window_next = {window_reg[2*BYTE_W-1:0], stream.data_byte};
        seen_next   = (seen_reg == SEEN_FULL) ? seen_reg : seen_reg + 1'b1;

        found0 = open_next[0] && (cnt_next[0] == '0);
        found1 = open_next[1] && (cnt_next[1] == '0);
        s1 = found0 ? sig_next[0] : NOT_FOUND;
        l1 = found0 ? loc_next[0] : NOT_FOUND;
        s2 = found1 ? sig_next[1] : NOT_FOUND;
        l2 = found1 ? loc_next[1] : NOT_FOUND;

        near_base = l2 - NEAR_OFFSET;
        near_diff = {1'b0, l1} - {1'b0, near_base};
        near      = !near_diff[WORD_W] && (near_diff[WORD_W-1:0] <= NEAR_SPAN);

        res_next.first_found  = found0;
        res_next.first_sig    = s1;
        res_next.first_loc    = l1;
        res_next.second_found = found1 && !near;
        res_next.second_sig   = near ? NOT_FOUND : s2;
        res_next.second_loc   = near ? NOT_FOUND : l2;
        res_next.pair_accept  = !(open_next[0] && open_next[1])
            || (is_color(s1, color0_reg, color1_reg) && is_color(s2, color0_reg, color1_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color0_reg <= FIRST_COLOR_RESET;
            color1_reg <= SECOND_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRST_COLOR_SIG:  color0_reg <= cfg_data;
                REG_SECOND_COLOR_SIG: color1_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            done_reg   <= 1'b0;
            open_reg   <= '0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                cnt_reg[s] <= '0;
                sig_reg[s] <= NOT_FOUND;
                loc_reg[s] <= NOT_FOUND;
            end
        end
        else if (take)
        begin
            if (stream.last_byte)
            begin
                window_reg <= '0;
                seen_reg   <= '0;
                done_reg   <= 1'b0;
                open_reg   <= '0;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    cnt_reg[s] <= '0;
                    sig_reg[s] <= NOT_FOUND;
                    loc_reg[s] <= NOT_FOUND;
                end
            end
            else
            begin
                window_reg <= window_next;
                seen_reg   <= seen_next;
                done_reg   <= done_next;
                open_reg   <= open_next;
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    cnt_reg[s] <= cnt_next[s];
                    sig_reg[s] <= sig_next[s];
                    loc_reg[s] <= loc_next[s];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && stream.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && stream.last_byte)
        begin
            out_reg <= res_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.first_found  = out_reg.first_found;
    assign result.first_sig    = out_reg.first_sig;
    assign result.first_loc    = out_reg.first_loc;
    assign result.second_found = out_reg.second_found;
    assign result.second_sig   = out_reg.second_sig;
    assign result.second_loc   = out_reg.second_loc;
    assign result.pair_accept  = out_reg.pair_accept;

endmodule

// File: bench/tb.sv
// Self-checking bench for the color code block stream parser: a queue-fed byte driver,
// a stalling result monitor and a byte-accurate predictor of the two capture slots.
// Depends on ccbsp_pkg, ccbsp_in_if, ccbsp_out_if and color_code_block_stream_parser.
`timescale 1ns / 100ps

module tb;
    import ccbsp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 115;

    localparam logic [7:0] HDR_SYNC = 8'h55;
    localparam logic [7:0] HDR_MARK = 8'haa;
    localparam logic [7:0] HDR_CC   = 8'h56;
    localparam logic [15:0] ABSENT  = 16'hffff;

    localparam logic [2:0] SLOT_ARM    = 3'd6;
    localparam logic [2:0] AT_SIG_LOW  = 3'd4;
    localparam logic [2:0] AT_SIG_HIGH = 3'd3;
    localparam logic [2:0] AT_LOC_LOW  = 3'd2;
    localparam logic [2:0] AT_LOC_HIGH = 3'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0] cfg_data;

    ccbsp_in_if  stream_if ();
    ccbsp_out_if result_if ();

    color_code_block_stream_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    stream_item_t byte_queue[$];
    result_t      buffer_reports[$];
    logic [7:0]   frame[$];

    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [23:0] win;
    logic [1:0]  seen;
    logic        slot_open [2];
    logic [2:0]  slot_cnt [2];
    logic [15:0] slot_sig [2];
    logic [15:0] slot_loc [2];
    logic        search_done;

    logic        no_idle;
    int          burst_left;
    int          gap_left;
    logic [15:0] ready_pattern;
    int          cycle_count;
    int          error_count;
    int          phase_items;
    result_t     want;
    stream_item_t next_item;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("Mismatch in %s at %0t: got %h, expected %h", what, $time, got, exp_val);
        error_count++;
    endtask

    task automatic clear_buffer_state();
        win = '0;
        seen = '0;
        search_done = 1'b0;
        for (int s = 0; s < 2; s++)
        begin
            slot_open[s] = 1'b0;
            slot_cnt[s] = '0;
            slot_sig[s] = ABSENT;
            slot_loc[s] = ABSENT;
        end
    endtask

    function automatic logic is_color(input logic [15:0] sig);
        return (sig == color_a) || (sig == color_b);
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic tail;
        logic lead;
        logic f1;
        logic f2;
        logic [15:0] s1;
        logic [15:0] l1;
        logic [15:0] s2;
        logic [15:0] l2;
        logic [15:0] d;
        result_t rep;
        for (int s = 0; s < 2; s++)
        begin
            if (slot_open[s] && slot_cnt[s] != 3'd0)
            begin
                case (slot_cnt[s])
                    AT_SIG_LOW:  slot_sig[s][7:0] = b;
                    AT_SIG_HIGH: slot_sig[s][15:8] = b;
                    AT_LOC_LOW:  slot_loc[s][7:0] = b;
                    AT_LOC_HIGH: slot_loc[s][15:8] = b;
                    default: ;
                endcase
                slot_cnt[s] = slot_cnt[s] - 3'd1;
            end
        end
        if (!search_done && seen == 2'd3)
        begin
            tail = (win[7:0] == HDR_CC) && (b == HDR_MARK);
            lead = (win[23:16] == HDR_SYNC) && (win[15:8] == HDR_MARK);
            if (tail && lead && !slot_open[0])
            begin
                slot_open[0] = 1'b1;
                slot_cnt[0] = SLOT_ARM;
            end
            else if (tail && !lead && !slot_open[1])
            begin
                slot_open[1] = 1'b1;
                slot_cnt[1] = SLOT_ARM;
            end
            if (slot_open[0] && slot_open[1])
                search_done = 1'b1;
        end
        win = {win[15:0], b};
        if (seen != 2'd3)
            seen = seen + 2'd1;
        if (last)
        begin
            f1 = slot_open[0] && slot_cnt[0] == 3'd0;
            f2 = slot_open[1] && slot_cnt[1] == 3'd0;
            s1 = f1 ? slot_sig[0] : ABSENT;
            l1 = f1 ? slot_loc[0] : ABSENT;
            s2 = f2 ? slot_sig[1] : ABSENT;
            l2 = f2 ? slot_loc[1] : ABSENT;
            rep.pair_accept = !(slot_open[0] && slot_open[1] && !(is_color(s1) && is_color(s2)));
            d = l2 - 16'd2;
            if (l1 >= d && (l1 - d) <= 16'd4)
            begin
                f2 = 1'b0;
                s2 = ABSENT;
                l2 = ABSENT;
            end
            rep.first_found = f1;
            rep.first_sig = s1;
            rep.first_loc = l1;
            rep.second_found = f2;
            rep.second_sig = s2;
            rep.second_loc = l2;
            buffer_reports.push_back(rep);
            clear_buffer_state();
        end
    endtask

    task automatic send_buffer();
        stream_item_t item;
        for (int i = 0; i < frame.size(); i++)
        begin
            item.data = frame[i];
            item.last = (i == frame.size() - 1);
            byte_queue.push_back(item);
        end
        phase_items += frame.size();
        frame.delete();
    endtask

    task automatic add_block(input logic first_hdr, input logic [15:0] sig,
                             input logic [15:0] loc);
        if (first_hdr)
        begin
            frame.push_back(HDR_SYNC);
            frame.push_back(HDR_MARK);
        end
        frame.push_back(HDR_CC);
        frame.push_back(HDR_MARK);
        frame.push_back(8'($urandom));
        frame.push_back(8'($urandom));
        frame.push_back(sig[7:0]);
        frame.push_back(sig[15:8]);
        frame.push_back(loc[7:0]);
        frame.push_back(loc[15:8]);
        repeat (6) frame.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] pick_sig();
        case ($urandom_range(0, 5))
            0, 1: return color_a;
            2, 3: return color_b;
            4: return 16'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
        endcase
    endfunction

    function automatic logic [15:0] pick_loc();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 3));
            1: return 16'hfffc + 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic make_buffer();
        logic [15:0] sa;
        logic [15:0] sb;
        logic [15:0] la;
        logic [15:0] lb;
        int kind;
        int cut;
        sa = pick_sig();
        sb = pick_sig();
        la = pick_loc();
        lb = ($urandom_range(0, 1) != 0) ? la + 16'($urandom_range(0, 8)) - 16'd4 : pick_loc();
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(0, 2)) frame.push_back(8'($urandom));
        case (kind)
            0, 1, 2, 3, 4:
            begin
                add_block(1'b1, sa, la);
                add_block(1'b0, sb, lb);
            end
            5:
            begin
                add_block(1'b0, sb, lb);
                add_block(1'b1, sa, la);
            end
            6: add_block(1'b1, sa, la);
            7: add_block(1'b0, sb, lb);
            8:
            begin
                add_block(1'b0, sb, lb);
                add_block(1'b0, sa, la);
                add_block(1'b1, sa, lb);
            end
            default: repeat ($urandom_range(1, 20)) frame.push_back(8'($urandom));
        endcase
        repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        if ($urandom_range(0, 3) == 0)
        begin
            cut = $urandom_range(1, frame.size());
            frame = frame[0:cut-1];
        end
        send_buffer();
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || stream_if.valid || buffer_reports.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_colors(input logic [15:0] first_val, input logic [15:0] second_val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_FIRST_COLOR_SIG;
        cfg_data <= first_val;
        @(posedge clk);
        cfg_index <= REG_SECOND_COLOR_SIG;
        cfg_data <= second_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        color_a = first_val;
        color_b = second_val;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            stream_if.valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
                parse_byte(stream_if.data_byte, stream_if.last_byte);
            if (!stream_if.valid || stream_if.ready)
            begin
                if (gap_left > 0 && !no_idle)
                begin
                    gap_left--;
                    stream_if.valid <= 1'b0;
                end
                else if (byte_queue.size() != 0)
                begin
                    next_item = byte_queue.pop_front();
                    stream_if.valid <= 1'b1;
                    stream_if.data_byte <= next_item.data;
                    stream_if.last_byte <= next_item.last;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = $urandom_range(0, 7);
                    end
                    else
                        burst_left--;
                end
                else
                    stream_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_if.ready <= 1'b0;
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (buffer_reports.size() == 0)
                    report_mismatch("unexpected result", 16'd0, 16'd0);
                else
                begin
                    want = buffer_reports.pop_front();
                    if (result_if.first_found !== want.first_found)
                        report_mismatch("first_found", 16'(result_if.first_found),
                                        16'(want.first_found));
                    if (result_if.first_sig !== want.first_sig)
                        report_mismatch("first_sig", result_if.first_sig, want.first_sig);
                    if (result_if.first_loc !== want.first_loc)
                        report_mismatch("first_loc", result_if.first_loc, want.first_loc);
                    if (result_if.second_found !== want.second_found)
                        report_mismatch("second_found", 16'(result_if.second_found),
                                        16'(want.second_found));
                    if (result_if.second_sig !== want.second_sig)
                        report_mismatch("second_sig", result_if.second_sig, want.second_sig);
                    if (result_if.second_loc !== want.second_loc)
                        report_mismatch("second_loc", result_if.second_loc, want.second_loc);
                    if (result_if.pair_accept !== want.pair_accept)
                        report_mismatch("pair_accept", 16'(result_if.pair_accept),
                                        16'(want.pair_accept));
                end
            end
            result_if.ready <= no_idle | ready_pattern[15];
            ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stream_if.valid = 1'b0;
        stream_if.data_byte = '0;
        stream_if.last_byte = 1'b0;
        result_if.ready = 1'b0;
        no_idle = 1'b0;
        ready_pattern = 16'b1011_0011_1000_1111;
        cycle_count = 0;
        error_count = 0;
        phase_items = 0;
        color_a = 16'd1;
        color_b = 16'd2;
        clear_buffer_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A one-byte buffer, a header on the last byte, then two complete blocks.
        frame = '{8'hff};
        send_buffer();
        frame = '{HDR_SYNC, HDR_MARK, HDR_CC, HDR_MARK};
        send_buffer();
        frame = '{HDR_SYNC, HDR_MARK, HDR_CC, HDR_MARK, 8'h00, 8'h00, 8'h01, 8'h00,
                  8'h00, 8'h00, HDR_CC, HDR_MARK, 8'hff, 8'hff, 8'h02, 8'h00,
                  8'hff, 8'hff};
        send_buffer();
        wait_drained();

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: write_colors(16'h0000, 16'hffff);
                1: write_colors(16'hffff, 16'h0000);
                2: write_colors(16'($urandom), 16'($urandom));
                3: write_colors(16'hffff, 16'hffff);
                default: write_colors(16'($urandom), 16'd1);
            endcase
            no_idle = (p == 2);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                make_buffer();
            wait_drained();
        end

        no_idle = 1'b0;
        repeat (8) @(negedge clk);
        if (buffer_reports.size() != 0)
            report_mismatch("results never delivered", 16'(buffer_reports.size()), 16'd0);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
